/* hw/rtl/nvs_pkg.sv */
// nvs_pkg: shared types and constants of the nearest vertex search core
// used by every module under hw/rtl, no dependencies of its own
`default_nettype none

package nvs_pkg;

  localparam int COORD_W = 24;  // width of one coordinate field
  localparam int MAG_W   = 24;  // magnitude of a coordinate difference
  localparam int SQ_W    = 2 * MAG_W;
  localparam int IDX_W   = 16;
  localparam int DIST_W  = 50;

  localparam int DEF_MAX_VERTICES = 65536;
  localparam int DEF_COORD_BITS   = 24;

  localparam int QUEUE_DEPTH = 4;  // power of two, pointers wrap
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_vertex;
  } nvs_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] min_distance_sq;
    logic              index_overflow;
  } nvs_out_t;

  // one classified vertex on its way from the front to the back
  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] mag_z;
    logic [IDX_W-1:0] index;
    logic             overflow;  // overflow seen so far in this set
    logic             last;
    logic             first;     // first vertex of a set, best restarts
  } nvs_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nvs_qstat_t;

endpackage

`default_nettype wire

/* hw/rtl/nvs_front.sv */
// nvs_front: accepts input transactions, latches query points, numbers vertices
// and pushes per-axis distance magnitudes into the queue; uses nvs_pkg
`default_nettype none

module nvs_front #(
  parameter int MAX_VERTICES = nvs_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = nvs_pkg::DEF_COORD_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire nvs_pkg::nvs_in_t    in_data_i,
  input  wire nvs_pkg::nvs_qstat_t qstat_i,
  output logic                     push_o,
  output nvs_pkg::nvs_entry_t      entry_o
);

  localparam int CW       = nvs_pkg::COORD_W;
  localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
  localparam int IDX_CAP  = (MAX_VERTICES - 1 > 65535) ? 65535 : MAX_VERTICES - 1;
  // wider formats than the field carry the field as an unsigned value
  localparam int SIGN_POS = (COORD_BITS > CW) ? CW - 1 : COORD_BITS - 1;
  localparam logic ZERO_EXT = (COORD_BITS > CW);

  function automatic logic signed [CW:0] ext_coord(logic [CW-1:0] raw);
    logic signed [CW:0] c;
    for (int i = 0; i < CW; i++) begin
      c[i] = (i > SIGN_POS) ? raw[SIGN_POS] : raw[i];
    end
    c[CW] = ZERO_EXT ? 1'b0 : raw[SIGN_POS];
    return c;
  endfunction

  function automatic logic [nvs_pkg::MAG_W-1:0] abs_diff(logic signed [CW:0] a,
                                                        logic signed [CW:0] b);
    logic signed [CW:0] d;
    logic signed [CW:0] n;
    d = a - b;
    n = -d;
    return d[CW] ? n[nvs_pkg::MAG_W-1:0] : d[nvs_pkg::MAG_W-1:0];
  endfunction

  logic signed [CW:0] query_x_q, query_x_d;
  logic signed [CW:0] query_y_q, query_y_d;
  logic signed [CW:0] query_z_q, query_z_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               first_q, first_d;

  logic signed [CW:0] vx, vy, vz;
  logic               accept;
  logic               is_vertex;
  logic               sat;
  logic               above_cap;
  logic               ovf_now;
  logic [nvs_pkg::IDX_W-1:0] idx;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign is_vertex  = (in_data_i.kind == nvs_pkg::KIND_VERTEX);
  assign push_o     = accept && is_vertex;

  assign vx = ext_coord(in_data_i.coord_x);
  assign vy = ext_coord(in_data_i.coord_y);
  assign vz = ext_coord(in_data_i.coord_z);

  assign sat       = (cnt_q >= CNT_W'(MAX_VERTICES));
  assign above_cap = (cnt_q > CNT_W'(IDX_CAP));
  assign ovf_now   = sat || above_cap;
  assign idx       = ovf_now ? nvs_pkg::IDX_W'(IDX_CAP) : nvs_pkg::IDX_W'(cnt_q);

  always_comb begin
    entry_o.mag_x    = abs_diff(vx, query_x_q);
    entry_o.mag_y    = abs_diff(vy, query_y_q);
    entry_o.mag_z    = abs_diff(vz, query_z_q);
    entry_o.index    = idx;
    entry_o.overflow = ovf_q || ovf_now;
    entry_o.last     = in_data_i.last_vertex;
    entry_o.first    = first_q;
  end

  always_comb begin
    query_x_d = query_x_q;
    query_y_d = query_y_q;
    query_z_d = query_z_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    first_d   = first_q;
    if (accept && !is_vertex) begin
      query_x_d = vx;
      query_y_d = vy;
      query_z_d = vz;
      cnt_d     = '0;
      ovf_d     = 1'b0;
      first_d   = 1'b1;
    end else if (push_o) begin
      if (in_data_i.last_vertex) begin
        cnt_d   = '0;
        ovf_d   = 1'b0;
        first_d = 1'b1;
      end else begin
        cnt_d   = sat ? cnt_q : cnt_q + CNT_W'(1);
        ovf_d   = ovf_q || ovf_now;
        first_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
      query_z_q <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      first_q   <= 1'b1;
    end else begin
      query_x_q <= query_x_d;
      query_y_q <= query_y_d;
      query_z_q <= query_z_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      first_q   <= first_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/nvs_queue.sv */
// nvs_queue: short fifo of classified vertices between front and back
// entry type and depth come from nvs_pkg
`default_nettype none

module nvs_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire nvs_pkg::nvs_entry_t wr_data_i,
  input  wire logic                pop_i,
  output nvs_pkg::nvs_entry_t      rd_data_o,
  output nvs_pkg::nvs_qstat_t      qstat_o
);

  nvs_pkg::nvs_entry_t              mem_q [nvs_pkg::QUEUE_DEPTH];
  logic [nvs_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [nvs_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [nvs_pkg::QCNT_W-1:0]       count_q, count_d;

  assign qstat_o.full  = (count_q == nvs_pkg::QCNT_W'(nvs_pkg::QUEUE_DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign rd_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + nvs_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + nvs_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + nvs_pkg::QCNT_W'(1);
      2'b01:   count_d = count_q - nvs_pkg::QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full)
    else $error("queue pushed while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

/* hw/rtl/nvs_back.sv */
// nvs_back: squares, sum, running minimum and output register of the search
// pulls classified vertices from nvs_queue; uses nvs_pkg
`default_nettype none

module nvs_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire nvs_pkg::nvs_qstat_t qstat_i,
  input  wire nvs_pkg::nvs_entry_t entry_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output nvs_pkg::nvs_out_t        out_data_o
);

  localparam int SQ_W   = nvs_pkg::SQ_W;
  localparam int DIST_W = nvs_pkg::DIST_W;
  localparam int IDX_W  = nvs_pkg::IDX_W;

  logic en;

  // stage 1: squared axis terms
  logic              s1_valid_q;
  logic [SQ_W-1:0]   s1_sq_x_q, s1_sq_y_q, s1_sq_z_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic              s1_ovf_q, s1_last_q, s1_first_q;
  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;

  // stage 2: squared distance
  logic              s2_valid_q;
  logic [DIST_W-1:0] s2_sum_q;
  logic [IDX_W-1:0]  s2_idx_q;
  logic              s2_ovf_q, s2_last_q, s2_first_q;

  // running best and output register
  logic [DIST_W-1:0] best_dist_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [DIST_W-1:0] base_dist, new_dist;
  logic [IDX_W-1:0]  base_idx, new_idx;
  logic              win;
  logic              out_valid_q;
  nvs_pkg::nvs_out_t out_data_q;

  // the whole back end holds while a result waits and the receiver stalls
  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && !qstat_i.empty;

  assign sq_x = entry_i.mag_x * entry_i.mag_x;
  assign sq_y = entry_i.mag_y * entry_i.mag_y;
  assign sq_z = entry_i.mag_z * entry_i.mag_z;

  always_comb begin
    base_dist = s2_first_q ? nvs_pkg::DIST_MAX : best_dist_q;
    base_idx  = s2_first_q ? '0 : best_idx_q;
    win       = (s2_sum_q < base_dist);  // strict, ties keep the earlier vertex
    new_dist  = win ? s2_sum_q : base_dist;
    new_idx   = win ? s2_idx_q : base_idx;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sq_x_q  <= sq_x;
      s1_sq_y_q  <= sq_y;
      s1_sq_z_q  <= sq_z;
      s1_idx_q   <= entry_i.index;
      s1_ovf_q   <= entry_i.overflow;
      s1_last_q  <= entry_i.last;
      s1_first_q <= entry_i.first;
      s2_sum_q   <= DIST_W'(s1_sq_x_q) + DIST_W'(s1_sq_y_q) + DIST_W'(s1_sq_z_q);
      s2_idx_q   <= s1_idx_q;
      s2_ovf_q   <= s1_ovf_q;
      s2_last_q  <= s1_last_q;
      s2_first_q <= s1_first_q;
      if (s2_valid_q && s2_last_q) begin
        out_data_q.nearest_index   <= new_idx;
        out_data_q.min_distance_sq <= new_dist;
        out_data_q.index_overflow  <= s2_ovf_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      best_dist_q <= nvs_pkg::DIST_MAX;
      best_idx_q  <= '0;
    end else if (en) begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q && s2_last_q;
      if (s2_valid_q) begin
        best_dist_q <= new_dist;
        best_idx_q  <= new_idx;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_first_vertex_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s2_valid_q && s2_first_q) |=> (best_dist_q == $past(s2_sum_q)))
    else $error("first vertex of a set did not become the best");

  a_result_has_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.min_distance_sq != nvs_pkg::DIST_MAX))
    else $error("result distance at the empty-set value");

endmodule

`default_nettype wire

/* hw/rtl/nearest_vertex_search_core.sv */
// nearest_vertex_search_core: top level of the brute-force nearest vertex search
// instantiates nvs_front, nvs_queue and nvs_back; types from nvs_pkg
//
// usage: send a query transaction (kind 0) with the query point, then stream
// mesh vertices (kind 1), one per cycle; the vertex with last_vertex set closes
// the set and one result transaction follows with the index of the closest
// vertex (earliest on ties), its squared distance and the index overflow flag.
// a query transaction gives no result, its last_vertex is ignored.
// throughput: one input transaction per cycle, queries and vertices alike,
// while in_stall_o is low. result path: the last vertex passes through the
// queue slot, the square stage and the sum stage ahead of the compare, which
// loads the output register.
// reset: query point is the origin, no set is open, nothing to clear.
// receiver stall: the result holds in the output register and the back end
// freezes; the four-entry queue keeps taking vertices until full, then
// in_stall_o rises. later sets reuse the last query point.
`default_nettype none

module nearest_vertex_search_core #(
  parameter int MAX_VERTICES = nvs_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = nvs_pkg::DEF_COORD_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire nvs_pkg::nvs_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output nvs_pkg::nvs_out_t      out_data_o
);

  nvs_pkg::nvs_qstat_t qstat;
  nvs_pkg::nvs_entry_t wr_entry;
  nvs_pkg::nvs_entry_t rd_entry;
  logic                push;
  logic                pop;

  nvs_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  nvs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_entry),
    .pop_i     (pop),
    .rd_data_o (rd_entry),
    .qstat_o   (qstat)
  );

  nvs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .entry_i     (rd_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// tb: self-checking testbench for nearest_vertex_search_core
// directed stimulus table, then random vertex sets checked against a local predictor
// depends on nvs_pkg for the transaction types and field widths
`timescale 1ns / 1ps

module tb;
  import nvs_pkg::*;

  localparam int MAXV = DEF_MAX_VERTICES;
  localparam int CBITS = DEF_COORD_BITS;
  localparam longint unsigned DIST_CEIL = (64'd1 << DIST_W) - 1;
  localparam longint unsigned IDX_SAT = (64'(MAXV) - 1 > 64'd65535) ? 64'd65535 : 64'(MAXV) - 1;
  localparam longint unsigned SPAN = (64'd1 << COORD_W) - 1;
  localparam longint unsigned HALF = SPAN >> 1;
  localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1730;

  typedef struct {
    nvs_in_t  item;
    bit       typed;
    nvs_out_t want;
  } plan_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  nvs_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b1;
  nvs_out_t out_data_o;

  bit        steady = 1'b0;
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  nvs_out_t  pending_nearest[$];
  plan_row_t plan[$];

  // predictor state
  longint          trk_qx, trk_qy, trk_qz;
  longint unsigned trk_best_idx, trk_best_dist, trk_count;
  bit              trk_ovf;

  nearest_vertex_search_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] %s", $realtime, what);
  endtask

  // the low CBITS bits carry the sign, wider formats read the field as unsigned
  function automatic longint to_signed(input logic [COORD_W-1:0] c);
    longint v;
    v = longint'(c);
    return (v <<< (64 - CBITS)) >>> (64 - CBITS);
  endfunction

  function automatic longint unsigned square_gap(input longint a, input longint b);
    longint d;
    longint unsigned m;
    d = a - b;
    m = (d < 0) ? -d : d;
    if (m > 64'd33554431) return DIST_CEIL;
    m = m * m;
    return (m > DIST_CEIL) ? DIST_CEIL : m;
  endfunction

  function automatic void restart_search();
    trk_best_idx = 0;
    trk_best_dist = DIST_CEIL;
    trk_count = 0;
    trk_ovf = 1'b0;
  endfunction

  task automatic nearest_track(input nvs_in_t t, output bit emits, output nvs_out_t r);
    longint x, y, z;
    longint unsigned sum_sq, idx;
    emits = 1'b0;
    r = '0;
    x = to_signed(t.coord_x);
    y = to_signed(t.coord_y);
    z = to_signed(t.coord_z);
    if (t.kind == KIND_QUERY) begin
      trk_qx = x;
      trk_qy = y;
      trk_qz = z;
      restart_search();
      return;
    end
    sum_sq = square_gap(x, trk_qx) + square_gap(y, trk_qy);
    if (sum_sq > DIST_CEIL) sum_sq = DIST_CEIL;
    sum_sq += square_gap(z, trk_qz);
    if (sum_sq > DIST_CEIL) sum_sq = DIST_CEIL;
    // past the index range every vertex competes under the saturated index
    if (trk_count >= 64'(MAXV)) begin
      trk_ovf = 1'b1;
      idx = IDX_SAT;
    end else begin
      idx = (trk_count > IDX_SAT) ? IDX_SAT : trk_count;
      if (trk_count > IDX_SAT) trk_ovf = 1'b1;
      trk_count++;
    end
    if (sum_sq < trk_best_dist) begin
      trk_best_dist = sum_sq;
      trk_best_idx = idx;
    end
    if (!t.last_vertex) return;
    emits = 1'b1;
    r.nearest_index = trk_best_idx[IDX_W-1:0];
    r.min_distance_sq = trk_best_dist[DIST_W-1:0];
    r.index_overflow = trk_ovf;
    restart_search();
  endtask

  function automatic nvs_in_t mk_point(input logic kind, input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y,
                                       input logic [COORD_W-1:0] z, input logic last);
    nvs_in_t p;
    p.kind = kind;
    p.coord_x = x;
    p.coord_y = y;
    p.coord_z = z;
    p.last_vertex = last;
    return p;
  endfunction

  function automatic void add_row(input nvs_in_t item, input bit typed,
                                  input longint unsigned idx, input longint unsigned want_sq,
                                  input bit ovf);
    plan_row_t row;
    row.item = item;
    row.typed = typed;
    row.want.nearest_index = idx[IDX_W-1:0];
    row.want.min_distance_sq = want_sq[DIST_W-1:0];
    row.want.index_overflow = ovf;
    plan = {plan, row};
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // a point a few steps away from the query, so that sets hold close contenders
  function automatic logic [COORD_W-1:0] jitter(input logic [COORD_W-1:0] base);
    return base + COORD_W'($urandom_range(0, 64)) - COORD_W'(32);
  endfunction

  task automatic send_point(input nvs_in_t t, input bit typed, input nvs_out_t want);
    int gap;
    bit emits;
    nvs_out_t r;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    nearest_track(t, emits, r);
    if (typed) r = want;
    if (emits) pending_nearest = {pending_nearest, r};
  endtask

  // result side: random stall before each transaction, then check
  initial begin : result_sink
    int n;
    nvs_out_t got, want;
    @(posedge rst_ni);
    forever begin
      n = steady ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = out_data_o;
      if (pending_nearest.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: index %0d dist %0d overflow %0b",
                                got.nearest_index, got.min_distance_sq, got.index_overflow));
      end else begin
        want = pending_nearest.pop_front();
        if (got.nearest_index !== want.nearest_index)
          flag_mismatch($sformatf("nearest_index %0d, expected %0d",
                                  got.nearest_index, want.nearest_index));
        if (got.min_distance_sq !== want.min_distance_sq)
          flag_mismatch($sformatf("min_distance_sq %0d, expected %0d",
                                  got.min_distance_sq, want.min_distance_sq));
        if (got.index_overflow !== want.index_overflow)
          flag_mismatch($sformatf("index_overflow %0b, expected %0b",
                                  got.index_overflow, want.index_overflow));
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent, n, mode;
    bit closes;
    nvs_in_t q, v, prev;
    nvs_out_t none;
    none = '0;
    trk_qx = 0;
    trk_qy = 0;
    trk_qz = 0;
    restart_search();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // vertices before any query measure against the origin
    add_row(mk_point(KIND_VERTEX, '0, '0, '0, 1'b1), 1'b1, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, C_MAX, C_MAX, C_MAX, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, C_MIN, C_MIN, C_MIN, 1'b1), 1'b1, 0, 3 * HALF * HALF, 1'b0);
    // query with the last mark set gives no result
    add_row(mk_point(KIND_QUERY, C_MIN, C_MIN, C_MIN, 1'b1), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, C_MAX, C_MAX, C_MAX, 1'b1), 1'b1, 0, 3 * SPAN * SPAN, 1'b0);
    // equal distances keep the earliest vertex
    add_row(mk_point(KIND_QUERY, '0, '0, '0, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, 1, 0, 0, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, 0, 0, -1, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, 0, 1, 0, 1'b1), 1'b1, 0, 1, 1'b0);
    add_row(mk_point(KIND_VERTEX, 5, 5, 5, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, 2, 0, 0, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, 0, 0, 1, 1'b1), 1'b1, 2, 1, 1'b0);
    add_row(mk_point(KIND_QUERY, 100, -200, 300, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, -4000, 77, 300, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, 100, -199, 300, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, 101, -200, 299, 1'b1), 1'b0, 0, 0, 1'b0);
    // query point survives the result
    add_row(mk_point(KIND_VERTEX, 100, -200, 300, 1'b1), 1'b1, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, C_MIN, C_MAX, '0, 1'b0), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_VERTEX, 24'h555555, 24'hAAAAAA, -1, 1'b1), 1'b0, 0, 0, 1'b0);
    add_row(mk_point(KIND_QUERY, 24'h2AAAAA, 24'hD55555, C_MAX, 1'b1), 1'b0, 0, 0, 1'b0);
    foreach (plan[i]) send_point(plan[i].item, plan[i].typed, plan[i].want);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 7) == 0);
      mode = $urandom_range(0, 9);
      if (mode < 8) begin
        q = mk_point(KIND_QUERY, rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
        send_point(q, 1'b0, none);
        sent++;
        n = $urandom_range(1, 12);
        closes = ($urandom_range(0, 9) != 0);
        prev = q;
        prev.kind = KIND_VERTEX;
        for (int k = 0; k < n; k++) begin
          if (k > 0 && $urandom_range(0, 7) == 0)
            v = prev;
          else if ($urandom_range(0, 2) == 0)
            v = mk_point(KIND_VERTEX, rand_coord(), rand_coord(), rand_coord(), 1'b0);
          else
            v = mk_point(KIND_VERTEX, jitter(q.coord_x), jitter(q.coord_y),
                         jitter(q.coord_z), 1'b0);
          v.last_vertex = closes && (k == n - 1);
          send_point(v, 1'b0, none);
          sent++;
          prev = v;
        end
      end else if (mode == 8) begin
        // stray vertex against whatever query is held
        v = mk_point(KIND_VERTEX, rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
        send_point(v, 1'b0, none);
        sent++;
      end else begin
        q = mk_point(KIND_QUERY, rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
        send_point(q, 1'b0, none);
        sent++;
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_nearest.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
